// ===== rtl/core/cdu_pkg.sv =====
package cdu_pkg;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_SAT      = 2'd2
    } t_status;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg_r;
        logic neg_i;
    } t_ctrl;

    localparam int unsigned OUT_WIDTH = 32;

endpackage

// ===== rtl/core/complex_divide_unit.sv =====
// Pipeline from start to o_valid: two product stages, one divider cell per quotient bit,
// and one saturation stage.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous active-low i_rst_n clears all valid flags; payload is not reset.
module complex_divide_unit
    import cdu_pkg::*;
#(
    parameter int unsigned DATA_WIDTH     = 16,
    parameter int unsigned QUOT_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [DATA_WIDTH-1:0]  i_num_real,
    input  logic signed [DATA_WIDTH-1:0]  i_num_imag,
    input  logic signed [DATA_WIDTH-1:0]  i_den_real,
    input  logic signed [DATA_WIDTH-1:0]  i_den_imag,
    output logic                          o_valid,
    output logic signed [OUT_WIDTH-1:0]   o_quot_real,
    output logic signed [OUT_WIDTH-1:0]   o_quot_imag,
    output logic [1:0]                    o_status
);

    localparam int unsigned RW = 2 * DATA_WIDTH;
    localparam int unsigned XW = RW + QUOT_FRAC_BITS;
    localparam int unsigned CW = (XW > OUT_WIDTH + 1) ? XW : OUT_WIDTH + 1;
    localparam logic [CW-1:0] POS_LIM = CW'({1'b0, {(OUT_WIDTH-1){1'b1}}});
    localparam logic [CW-1:0] NEG_LIM = CW'({1'b1, {(OUT_WIDTH-1){1'b0}}});

    logic [RW-1:0] w_den   [0:XW];
    logic [RW-1:0] w_rem_r [0:XW];
    logic [RW-1:0] w_rem_i [0:XW];
    logic [XW-1:0] w_x_r   [0:XW];
    logic [XW-1:0] w_x_i   [0:XW];
    t_ctrl         w_ctrl  [0:XW];
    logic [RW-1:0] w_mag_r, w_mag_i;

    logic [CW-1:0]        n_q_r, n_q_i, n_lim_r, n_lim_i;
    logic                 n_sat_r, n_sat_i;
    logic [OUT_WIDTH-1:0] n_v_r, n_v_i;
    logic                 r_valid;
    logic [OUT_WIDTH-1:0] r_q_r, r_q_i;
    t_status              r_status;

    assign busy = 1'b0;

    cdu_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (start && !busy),
        .i_num_real (i_num_real),
        .i_num_imag (i_num_imag),
        .i_den_real (i_den_real),
        .i_den_imag (i_den_imag),
        .o_den      (w_den[0]),
        .o_mag_r    (w_mag_r),
        .o_mag_i    (w_mag_i),
        .o_ctrl     (w_ctrl[0])
    );

    assign w_rem_r[0] = '0;
    assign w_rem_i[0] = '0;
    assign w_x_r[0]   = {w_mag_r, {QUOT_FRAC_BITS{1'b0}}};
    assign w_x_i[0]   = {w_mag_i, {QUOT_FRAC_BITS{1'b0}}};

    for (genvar k = 0; k < XW; k++) begin : g_cell
        cdu_cell #(.RW(RW), .XW(XW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_den   (w_den[k]),
            .i_rem_r (w_rem_r[k]),
            .i_rem_i (w_rem_i[k]),
            .i_x_r   (w_x_r[k]),
            .i_x_i   (w_x_i[k]),
            .i_ctrl  (w_ctrl[k]),
            .o_den   (w_den[k+1]),
            .o_rem_r (w_rem_r[k+1]),
            .o_rem_i (w_rem_i[k+1]),
            .o_x_r   (w_x_r[k+1]),
            .o_x_i   (w_x_i[k+1]),
            .o_ctrl  (w_ctrl[k+1])
        );
    end

    assign n_q_r   = CW'(w_x_r[XW]);
    assign n_q_i   = CW'(w_x_i[XW]);
    assign n_lim_r = w_ctrl[XW].neg_r ? NEG_LIM : POS_LIM;
    assign n_lim_i = w_ctrl[XW].neg_i ? NEG_LIM : POS_LIM;
    assign n_sat_r = (n_q_r > n_lim_r);
    assign n_sat_i = (n_q_i > n_lim_i);
    assign n_v_r   = n_sat_r ? OUT_WIDTH'(n_lim_r) : OUT_WIDTH'(n_q_r);
    assign n_v_i   = n_sat_i ? OUT_WIDTH'(n_lim_i) : OUT_WIDTH'(n_q_i);

    always_ff @(posedge i_clk) begin
        if (w_ctrl[XW].zero) begin
            r_q_r    <= '0;
            r_q_i    <= '0;
            r_status <= STATUS_DIV_ZERO;
        end else begin
            r_q_r    <= w_ctrl[XW].neg_r ? OUT_WIDTH'(-n_v_r) : n_v_r;
            r_q_i    <= w_ctrl[XW].neg_i ? OUT_WIDTH'(-n_v_i) : n_v_i;
            r_status <= (n_sat_r || n_sat_i) ? STATUS_SAT : STATUS_OK;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctrl[XW].valid;
        end
    end

    assign o_valid     = r_valid;
    assign o_quot_real = r_q_r;
    assign o_quot_imag = r_q_i;
    assign o_status    = r_status;

endmodule

// ===== rtl/core/cdu_prep.sv =====
module cdu_prep
    import cdu_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [DATA_WIDTH-1:0]  i_num_real,
    input  logic signed [DATA_WIDTH-1:0]  i_num_imag,
    input  logic signed [DATA_WIDTH-1:0]  i_den_real,
    input  logic signed [DATA_WIDTH-1:0]  i_den_imag,
    output logic [2*DATA_WIDTH-1:0]       o_den,
    output logic [2*DATA_WIDTH-1:0]       o_mag_r,
    output logic [2*DATA_WIDTH-1:0]       o_mag_i,
    output t_ctrl                         o_ctrl
);

    localparam int unsigned PW = 2 * DATA_WIDTH;

    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_nrdr, r_p_nidi, r_p_nidr, r_p_nrdi;
    logic                 r_v1;
    logic signed [PW:0]   n_sum_r, n_sum_i;
    logic [PW-1:0]        n_den;
    logic [PW-1:0]        r_den, r_mag_r, r_mag_i;
    t_ctrl                r_ctrl;

    always_ff @(posedge i_clk) begin
        r_p_rr   <= i_den_real * i_den_real;
        r_p_ii   <= i_den_imag * i_den_imag;
        r_p_nrdr <= i_num_real * i_den_real;
        r_p_nidi <= i_num_imag * i_den_imag;
        r_p_nidr <= i_num_imag * i_den_real;
        r_p_nrdi <= i_num_real * i_den_imag;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
        end
    end

    assign n_sum_r = (PW+1)'(r_p_nrdr) + (PW+1)'(r_p_nidi);
    assign n_sum_i = (PW+1)'(r_p_nidr) - (PW+1)'(r_p_nrdi);
    assign n_den   = $unsigned(r_p_rr) + $unsigned(r_p_ii);

    always_ff @(posedge i_clk) begin
        r_den   <= n_den;
        r_mag_r <= n_sum_r[PW] ? PW'(-n_sum_r) : PW'(n_sum_r);
        r_mag_i <= n_sum_i[PW] ? PW'(-n_sum_i) : PW'(n_sum_i);
        r_ctrl.zero  <= (n_den == '0);
        r_ctrl.neg_r <= n_sum_r[PW];
        r_ctrl.neg_i <= n_sum_i[PW];
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else begin
            r_ctrl.valid <= r_v1;
        end
    end

    assign o_den   = r_den;
    assign o_mag_r = r_mag_r;
    assign o_mag_i = r_mag_i;
    assign o_ctrl  = r_ctrl;

endmodule

// ===== rtl/core/cdu_cell.sv =====
module cdu_cell
    import cdu_pkg::*;
#(
    parameter int unsigned RW = 32,
    parameter int unsigned XW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [RW-1:0] i_den,
    input  logic [RW-1:0] i_rem_r,
    input  logic [RW-1:0] i_rem_i,
    input  logic [XW-1:0] i_x_r,
    input  logic [XW-1:0] i_x_i,
    input  t_ctrl         i_ctrl,
    output logic [RW-1:0] o_den,
    output logic [RW-1:0] o_rem_r,
    output logic [RW-1:0] o_rem_i,
    output logic [XW-1:0] o_x_r,
    output logic [XW-1:0] o_x_i,
    output t_ctrl         o_ctrl
);

    logic [RW:0]   n_trial_r, n_trial_i;
    logic          n_ge_r, n_ge_i;
    logic [RW-1:0] r_den, r_rem_r, r_rem_i;
    logic [XW-1:0] r_x_r, r_x_i;
    t_ctrl         r_ctrl;

    assign n_trial_r = {i_rem_r, i_x_r[XW-1]};
    assign n_trial_i = {i_rem_i, i_x_i[XW-1]};
    assign n_ge_r    = (n_trial_r >= {1'b0, i_den});
    assign n_ge_i    = (n_trial_i >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        r_den   <= i_den;
        r_rem_r <= n_ge_r ? RW'(n_trial_r - {1'b0, i_den}) : RW'(n_trial_r);
        r_rem_i <= n_ge_i ? RW'(n_trial_i - {1'b0, i_den}) : RW'(n_trial_i);
        r_x_r   <= {i_x_r[XW-2:0], n_ge_r};
        r_x_i   <= {i_x_i[XW-2:0], n_ge_i};
        r_ctrl.zero  <= i_ctrl.zero;
        r_ctrl.neg_r <= i_ctrl.neg_r;
        r_ctrl.neg_i <= i_ctrl.neg_i;
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else begin
            r_ctrl.valid <= i_ctrl.valid;
        end
    end

    assign o_den   = r_den;
    assign o_rem_r = r_rem_r;
    assign o_rem_i = r_rem_i;
    assign o_x_r   = r_x_r;
    assign o_x_i   = r_x_i;
    assign o_ctrl  = r_ctrl;

endmodule

// ===== rtl/core/cdu_checker.sv =====
module cdu_checker
    import cdu_pkg::*;
#(
    parameter int unsigned DATA_WIDTH     = 16,
    parameter int unsigned QUOT_FRAC_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [DATA_WIDTH-1:0] i_num_real,
    input logic signed [DATA_WIDTH-1:0] i_num_imag,
    input logic signed [DATA_WIDTH-1:0] i_den_real,
    input logic signed [DATA_WIDTH-1:0] i_den_imag,
    input logic                         o_valid,
    input logic signed [OUT_WIDTH-1:0]  o_quot_real,
    input logic signed [OUT_WIDTH-1:0]  o_quot_imag,
    input logic [1:0]                   o_status
);

    localparam int unsigned LAT = 2 * DATA_WIDTH + QUOT_FRAC_BITS + 3;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("item lost");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_den_real == '0 && i_den_imag == '0)
        |-> ##LAT (o_status == STATUS_DIV_ZERO && o_quot_real == '0 && o_quot_imag == '0))
        else $error("zero divisor not flagged");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STATUS_OK || o_status == STATUS_DIV_ZERO
                     || o_status == STATUS_SAT))
        else $error("bad status");

endmodule

bind complex_divide_unit cdu_checker #(
    .DATA_WIDTH     (DATA_WIDTH),
    .QUOT_FRAC_BITS (QUOT_FRAC_BITS)
) u_cdu_checker (.*);

// ===== tb/sv/complex_divide_unit_checker.sv =====
`timescale 1ns / 1ps

module complex_divide_unit_checker
    import cdu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_num_real,
    input  logic signed [15:0] i_num_imag,
    input  logic signed [15:0] i_den_real,
    input  logic signed [15:0] i_den_imag,
    input  logic               o_valid,
    input  logic signed [31:0] o_quot_real,
    input  logic signed [31:0] o_quot_imag,
    input  logic [1:0]         o_status,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [31:0] qr;
        logic signed [31:0] qi;
        t_status            status;
    } t_quotient;

    t_quotient quotient_q[$];

    assign o_pending = quotient_q.size();

    initial o_fail_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // Truncate toward zero, then clamp to the signed 32-bit range.
    function automatic logic [31:0] divide_part(input longint n, input longint d,
                                                inout logic sat);
        logic          neg;
        logic [127:0]  m;
        logic [127:0]  q;
        neg = n < 0;
        m = neg ? -n : n;
        q = (m << 16) / d;
        if (!neg && q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (neg && q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_quotient predict_quotient(input longint nr, input longint ni,
                                                   input longint dr, input longint di);
        t_quotient r;
        logic      sat;
        sat = 1'b0;
        if (dr == 0 && di == 0) begin
            r.qr = '0;
            r.qi = '0;
            r.status = STATUS_DIV_ZERO;
            return r;
        end
        r.qr = divide_part(nr * dr + ni * di, dr * dr + di * di, sat);
        r.qi = divide_part(ni * dr - nr * di, dr * dr + di * di, sat);
        r.status = sat ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_quotient want;
        if (i_rst_n && start && !busy)
            quotient_q.push_back(predict_quotient(i_num_real, i_num_imag,
                                                  i_den_real, i_den_imag));
        if (i_rst_n && o_valid) begin
            if (quotient_q.size() == 0) begin
                report_mismatch("unexpected result", o_quot_real, 0);
            end else begin
                want = quotient_q.pop_front();
                if (o_quot_real !== want.qr) report_mismatch("quot_real", o_quot_real, want.qr);
                if (o_quot_imag !== want.qi) report_mismatch("quot_imag", o_quot_imag, want.qi);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

endmodule

// ===== tb/sv/complex_divide_unit_tb.sv =====
`timescale 1ns / 1ps

module complex_divide_unit_tb;
    import cdu_pkg::*;

    localparam int LATENCY  = 51;
    localparam int WATCHDOG = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_num_real = '0;
    logic signed [15:0] i_num_imag = '0;
    logic signed [15:0] i_den_real = '0;
    logic signed [15:0] i_den_imag = '0;
    logic               o_valid;
    logic signed [31:0] o_quot_real;
    logic signed [31:0] o_quot_imag;
    logic [1:0]         o_status;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    complex_divide_unit dut (.*);

    complex_divide_unit_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("complex_divide_unit verification failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_part();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 8)) - 4);
            4: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [15:0] nr, input logic [15:0] ni,
                             input logic [15:0] dr, input logic [15:0] di);
        int gap;
        start      <= 1'b1;
        i_num_real <= nr;
        i_num_imag <= ni;
        i_den_real <= dr;
        i_den_imag <= di;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] corner [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_item(16'h1234, 16'h4321, 16'h0000, 16'h0000);
        send_item(16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
        send_item(16'h8000, 16'h8000, 16'h0000, 16'h0001);
        send_item(16'h8000, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
        send_item(16'h4000, 16'h0000, 16'h0000, 16'h4000);
        send_item(16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000);
        send_item(16'h0001, 16'h0000, 16'h0000, 16'h8000);
        for (int k = 0; k < 10; k++)
            send_item(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)],
                      corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)]);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int k = 0; k < 850; k++)
            send_item(pick_part(), pick_part(), pick_part(), pick_part());
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("complex_divide_unit verification clean");
        end else begin
            $display("complex_divide_unit verification failed");
        end
        $finish;
    end

endmodule
